[hw/rtl/ttyciq_pkg.sv]
// shared types and constants of the tty canonical input queue
package ttyciq_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int COUNT_FIELD_W = 11;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // stream payload widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 3;

  // input_flags bit positions
  localparam int FL_CANON  = 0;
  localparam int FL_STRIP  = 1;
  localparam int FL_LCASE  = 2;
  localparam int FL_EXTEND = 3;
  localparam int FL_IGNCR  = 4;
  localparam int FL_ICRNL  = 5;
  localparam int FL_INLCR  = 6;
  localparam int FL_ISIG   = 7;

  // register reset values
  localparam logic [7:0]  RST_INPUT_FLAGS  = 8'd169;
  localparam logic [23:0] RST_SIGNAL_CHARS = 24'h1A1C03;
  localparam logic [23:0] RST_ERASE_CHARS  = 24'h17157F;
  localparam logic [7:0]  RST_EOF_CODE     = 8'h04;
  localparam logic [7:0]  RST_EOL_CHAR     = 8'h00;

  // character constants
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_UC_A     = 8'h41;
  localparam logic [7:0] CH_UC_Z     = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] STRIP_MASK  = 8'h7F;
  localparam logic [7:0] CH_ZERO     = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_FLAGS  = 3'd0,
    REG_SIGNAL_CHARS = 3'd1,
    REG_ERASE_CHARS  = 3'd2,
    REG_EOF_CODE     = 3'd3,
    REG_EOL_CHAR     = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_QUEUED      = 3'd0,
    ST_CR_IGNORED  = 3'd1,
    ST_SIGNAL      = 3'd2,
    ST_ERASED      = 3'd3,
    ST_ERASE_EMPTY = 3'd4,
    ST_FULL        = 3'd5,
    ST_POPPED      = 3'd6,
    ST_NONE        = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    SIG_NONE = 2'd0,
    SIG_INTR = 2'd1,
    SIG_QUIT = 2'd2,
    SIG_SUSP = 2'd3
  } sig_kind_e;

  typedef enum logic [2:0] {
    ACT_QUEUE     = 3'd0,
    ACT_CR_IGNORE = 3'd1,
    ACT_SIGNAL    = 3'd2,
    ACT_ERASE     = 3'd3,
    ACT_POP       = 3'd4
  } action_e;

  typedef struct packed {
    logic [7:0]  input_flags;
    logic [23:0] signal_chars;
    logic [23:0] erase_chars;
    logic [7:0]  eof_code;
    logic [7:0]  eol_char;
  } cfg_t;

  typedef struct packed {
    action_e    action;
    sig_kind_e  kind;
    logic [7:0] ch_val;
    logic       mark;
  } act_t;

endpackage

[hw/rtl/ttyciq_classify.sv]
// byte classification: canonical mapping, signal and erase matching
module ttyciq_classify (
  input  logic              op_i,
  input  logic [7:0]        rx_byte_i,
  input  ttyciq_pkg::cfg_t  cfg_i,
  output ttyciq_pkg::act_t  act_o
);
  import ttyciq_pkg::*;

  logic       canon, ext;
  logic [7:0] ch_strip, ch_lc, ch_map;
  logic       cr_ignore;
  sig_kind_e  kind;
  logic       erase_hit;
  logic       raw_mark, map_mark;

  assign canon = cfg_i.input_flags[FL_CANON];
  assign ext   = cfg_i.input_flags[FL_EXTEND];

  assign ch_strip = cfg_i.input_flags[FL_STRIP] ? (rx_byte_i & STRIP_MASK) : rx_byte_i;

  always_comb begin
    ch_lc = ch_strip;
    if (cfg_i.input_flags[FL_LCASE] && ext && ch_strip >= CH_UC_A && ch_strip <= CH_UC_Z) begin
      ch_lc = ch_strip + CASE_OFFSET;
    end
  end

  // ignore cr wins over cr to nl
  always_comb begin
    ch_map    = ch_lc;
    cr_ignore = 1'b0;
    if (ch_lc == CH_CR) begin
      if (cfg_i.input_flags[FL_IGNCR]) begin
        cr_ignore = 1'b1;
      end else if (cfg_i.input_flags[FL_ICRNL]) begin
        ch_map = CH_NL;
      end
    end else if (ch_lc == CH_NL && cfg_i.input_flags[FL_INLCR]) begin
      ch_map = CH_CR;
    end
  end

  // interrupt before quit before suspend
  always_comb begin
    kind = SIG_NONE;
    if (cfg_i.input_flags[FL_ISIG]) begin
      if (ch_map == cfg_i.signal_chars[7:0]) begin
        kind = SIG_INTR;
      end else if (ch_map == cfg_i.signal_chars[15:8]) begin
        kind = SIG_QUIT;
      end else if (ch_map == cfg_i.signal_chars[23:16]) begin
        kind = SIG_SUSP;
      end
    end
  end

  assign erase_hit = (ch_map == cfg_i.erase_chars[7:0]) ||
                     (ch_map == cfg_i.erase_chars[15:8]) ||
                     (ext && ch_map == cfg_i.erase_chars[23:16]);

  assign raw_mark = (rx_byte_i == CH_NL) ||
                    (cfg_i.eol_char != CH_ZERO && rx_byte_i == cfg_i.eol_char);
  assign map_mark = (ch_map == CH_NL) ||
                    (cfg_i.eol_char != CH_ZERO && ch_map == cfg_i.eol_char);

  always_comb begin
    act_o.action = ACT_QUEUE;
    act_o.kind   = SIG_NONE;
    act_o.ch_val = rx_byte_i;
    act_o.mark   = raw_mark;
    if (op_i) begin
      act_o.action = ACT_POP;
    end else if (canon) begin
      act_o.ch_val = ch_map;
      act_o.mark   = map_mark;
      if (cr_ignore) begin
        act_o.action = ACT_CR_IGNORE;
      end else if (kind != SIG_NONE) begin
        act_o.action = ACT_SIGNAL;
        act_o.kind   = kind;
      end else if (erase_hit) begin
        act_o.action = ACT_ERASE;
      end else if (ch_map == cfg_i.eof_code) begin
        act_o.ch_val = CH_ZERO;
        act_o.mark   = 1'b1;
      end
    end
  end

endmodule

[hw/rtl/tty_canonical_input_queue_unit.sv]
// top level of the tty canonical input queue: line discipline and ring queue
// Terminal input line discipline in front of a 1024-entry ring queue of bytes,
// each with a line separator mark. A request with tuser 0 receives the byte in
// tdata; in canonical mode it is stripped, lowercased and CR/NL mapped, turned
// into a signal report, an erase of the last queued byte, an ignored CR, or
// queued (the EOF character as a marked zero). A request with tuser 1 pops
// one byte, in canonical mode only while a complete line is queued. Every
// request gives exactly one result. Throughput is one request per clock
// while the output register is free: a request sits in the input register,
// and once the output register is free its action and the queue pointer
// updates are done and the result lands in the output register; a held
// output register keeps the request waiting in the input register. The
// queue memory has one write port at the tail and two registered read ports
// that are prefetched each cycle at the next head and at the entry before
// the next tail, with a bypass of a same-cycle write, so pop and erase find
// their data in time.
// The memory has no reset and no clearing pass; only written entries are read.
// Configuration registers may be written only while no request is in flight.
module tty_canonical_input_queue_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // receive and pop requests
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [ttyciq_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // rx_byte[7:0]
  input  logic                                   s_axis_tuser,  // op
  // results
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // signal_kind[1:0], data_byte[9:2], was_separator[10], fill_count[21:11],
  // line_count[32:22], readable[33], writable[34], zero[39:35]
  output logic [ttyciq_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic [ttyciq_pkg::OUT_USER_W-1:0]      m_axis_tuser,  // status[2:0]
  // configuration writes
  input  logic                                   cfg_we_i,
  input  logic [ttyciq_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ttyciq_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import ttyciq_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.input_flags  <= RST_INPUT_FLAGS;
      cfg_q.signal_chars <= RST_SIGNAL_CHARS;
      cfg_q.erase_chars  <= RST_ERASE_CHARS;
      cfg_q.eof_code     <= RST_EOF_CODE;
      cfg_q.eol_char     <= RST_EOL_CHAR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INPUT_FLAGS:  cfg_q.input_flags  <= cfg_wdata_i[7:0];
        REG_SIGNAL_CHARS: cfg_q.signal_chars <= cfg_wdata_i;
        REG_ERASE_CHARS:  cfg_q.erase_chars  <= cfg_wdata_i;
        REG_EOF_CODE:     cfg_q.eof_code     <= cfg_wdata_i[7:0];
        REG_EOL_CHAR:     cfg_q.eol_char     <= cfg_wdata_i[7:0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // input register
  logic       in_valid_q, in_valid_d;
  logic       in_op_q;
  logic [7:0] in_byte_q;
  logic       in_accept, advance;

  // output register
  logic                     out_valid_q, out_valid_d;
  status_e                  out_status_q;
  sig_kind_e                out_kind_q;
  logic [7:0]               out_data_q;
  logic                     out_sep_q;
  logic [COUNT_FIELD_W-1:0] out_fill_q, out_line_q;
  logic                     out_readable_q, out_writable_q;

  // the item in the input register moves on once the output register is free
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_op_q   <= s_axis_tuser;
      in_byte_q <= s_axis_tdata[7:0];
    end
  end

  // classification of the pending request
  act_t act;

  ttyciq_classify u_classify (
    .op_i      (in_op_q),
    .rx_byte_i (in_byte_q),
    .cfg_i     (cfg_q),
    .act_o     (act)
  );

  // queue state
  logic [ADDR_W-1:0] head_q, head_d, tail_q, tail_d, last_addr_d;
  logic [CNT_W-1:0]  byte_count_q, byte_count_d, sep_count_q, sep_count_d;

  // queue memory: mark in bit 8, byte in bits 7:0
  logic [8:0]        char_store [QUEUE_DEPTH];
  logic              mem_we;
  logic [8:0]        mem_wdata;
  logic [8:0]        head_rdata_q, last_rdata_q, byp_data_q;
  logic              head_hit_q, last_hit_q;
  logic [8:0]        head_entry, last_entry;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      char_store[tail_q] <= mem_wdata;
    end
    head_rdata_q <= char_store[head_d];
    last_rdata_q <= char_store[last_addr_d];
    // a write to an address read in the same cycle is forwarded
    head_hit_q   <= mem_we && (tail_q == head_d);
    last_hit_q   <= mem_we && (tail_q == last_addr_d);
    byp_data_q   <= mem_wdata;
  end

  assign head_entry = head_hit_q ? byp_data_q : head_rdata_q;
  assign last_entry = last_hit_q ? byp_data_q : last_rdata_q;

  // entry before the next tail, read ahead for a following erase
  assign last_addr_d = (tail_d == '0) ? LAST_ADDR : tail_d - ADDR_W'(1);

  logic      canon;
  logic      pop_ok;
  status_e   res_status;
  sig_kind_e res_kind;
  logic [7:0] res_data;
  logic      res_sep;

  assign canon     = cfg_q.input_flags[FL_CANON];
  assign pop_ok    = (canon ? (sep_count_q != '0) : 1'b1) && (byte_count_q != '0);
  assign mem_wdata = {act.mark, act.ch_val};

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    byte_count_d = byte_count_q;
    sep_count_d  = sep_count_q;
    mem_we       = 1'b0;
    res_status   = ST_QUEUED;
    res_kind     = SIG_NONE;
    res_data     = '0;
    res_sep      = 1'b0;
    if (advance) begin
      case (act.action)
        ACT_POP: begin
          if (pop_ok) begin
            head_d       = (head_q == LAST_ADDR) ? '0 : head_q + ADDR_W'(1);
            byte_count_d = byte_count_q - CNT_W'(1);
            res_data     = head_entry[7:0];
            res_sep      = head_entry[8];
            if (head_entry[8] && sep_count_q != '0) begin
              sep_count_d = sep_count_q - CNT_W'(1);
            end
            res_status = ST_POPPED;
          end else begin
            res_status = ST_NONE;
          end
        end
        ACT_QUEUE: begin
          if (byte_count_q == FULL_CNT) begin
            res_status = ST_FULL;
          end else begin
            mem_we       = 1'b1;
            tail_d       = (tail_q == LAST_ADDR) ? '0 : tail_q + ADDR_W'(1);
            byte_count_d = byte_count_q + CNT_W'(1);
            if (act.mark) begin
              sep_count_d = sep_count_q + CNT_W'(1);
            end
            res_status = ST_QUEUED;
          end
        end
        ACT_ERASE: begin
          // erase, kill and word erase all drop just the last byte
          if (byte_count_q == '0) begin
            res_status = ST_ERASE_EMPTY;
          end else begin
            tail_d       = (tail_q == '0) ? LAST_ADDR : tail_q - ADDR_W'(1);
            byte_count_d = byte_count_q - CNT_W'(1);
            if (last_entry[8] && sep_count_q != '0) begin
              sep_count_d = sep_count_q - CNT_W'(1);
            end
            res_status = ST_ERASED;
          end
        end
        ACT_SIGNAL: begin
          res_status = ST_SIGNAL;
          res_kind   = act.kind;
        end
        ACT_CR_IGNORE: begin
          res_status = ST_CR_IGNORED;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      tail_q       <= '0;
      byte_count_q <= '0;
      sep_count_q  <= '0;
    end else begin
      head_q       <= head_d;
      tail_q       <= tail_d;
      byte_count_q <= byte_count_d;
      sep_count_q  <= sep_count_d;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_status_q   <= res_status;
      out_kind_q     <= res_kind;
      out_data_q     <= res_data;
      out_sep_q      <= res_sep;
      out_fill_q     <= COUNT_FIELD_W'(byte_count_d);
      out_line_q     <= COUNT_FIELD_W'(sep_count_d);
      out_readable_q <= canon ? (sep_count_d != '0) : (byte_count_d != '0);
      out_writable_q <= (byte_count_d != FULL_CNT);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {5'b0, out_writable_q, out_readable_q, out_line_q, out_fill_q,
                          out_sep_q, out_data_q, out_kind_q};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q <= FULL_CNT)
    else $error("queue fill count beyond depth");

  a_sep_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sep_count_q <= byte_count_q)
    else $error("more separators than queued bytes");

  a_ptr_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(head_q) + 32'(byte_count_q) == 32'(tail_q)) ||
    (32'(head_q) + 32'(byte_count_q) == 32'(tail_q) + 32'(QUEUE_DEPTH)))
    else $error("head, tail and fill count disagree");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (byte_count_q != FULL_CNT))
    else $error("write into a full queue");

  a_pop_drops_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && act.action == ACT_POP && pop_ok) |=>
      (byte_count_q == $past(byte_count_q) - CNT_W'(1)))
    else $error("pop did not remove exactly one byte");
`endif

endmodule

[tb/tty_canonical_input_queue_unit_tb.sv]
// self-checking testbench of the tty canonical input queue unit
`timescale 1ns / 100ps

module tty_canonical_input_queue_unit_tb;
  import ttyciq_pkg::*;

  // request kinds carried on s_axis_tuser
  localparam bit OP_RECEIVE = 1'b0;
  localparam bit OP_POP     = 1'b1;

  // cycles with no handshake on either side before the run is declared hung
  localparam int IDLE_LIMIT = 3000;
  // length of the forced receiver hold-off
  localparam int LONG_HOLD  = 150;

  // one result as the block reports it
  typedef struct {
    status_e    status;
    sig_kind_e  kind;
    logic [7:0] data_byte;
    logic       was_sep;
    logic [10:0] fill;
    logic [10:0] lines;
    logic       readable;
    logic       writable;
  } outcome_t;

  // mirror of the line discipline and its ring queue, plus the outcome fifo
  class line_queue_scoreboard;
    cfg_t        cfg;
    logic [8:0]  char_store [QUEUE_DEPTH];
    int unsigned head_idx;
    int unsigned tail_idx;
    int unsigned byte_cnt;
    int unsigned sep_cnt;
    outcome_t    pending_outcomes [$];
    int unsigned errors;

    function new();
      cfg.input_flags  = RST_INPUT_FLAGS;
      cfg.signal_chars = RST_SIGNAL_CHARS;
      cfg.erase_chars  = RST_ERASE_CHARS;
      cfg.eof_code     = RST_EOF_CODE;
      cfg.eol_char     = RST_EOL_CHAR;
      head_idx = 0;
      tail_idx = 0;
      byte_cnt = 0;
      sep_cnt  = 0;
      errors   = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_INPUT_FLAGS:  cfg.input_flags  = val[7:0];
        REG_SIGNAL_CHARS: cfg.signal_chars = val;
        REG_ERASE_CHARS:  cfg.erase_chars  = val;
        REG_EOF_CODE:     cfg.eof_code     = val[7:0];
        REG_EOL_CHAR:     cfg.eol_char     = val[7:0];
        default: ;
      endcase
    endfunction

    function bit is_line_end(logic [7:0] ch);
      return ch == CH_NL || (cfg.eol_char != CH_ZERO && ch == cfg.eol_char);
    endfunction

    function status_e store_byte(logic [7:0] ch, bit mark);
      if (byte_cnt >= QUEUE_DEPTH) return ST_FULL;
      char_store[tail_idx] = {mark, ch};
      tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
      byte_cnt++;
      if (mark) sep_cnt++;
      return ST_QUEUED;
    endfunction

    // predict the outcome of one accepted request
    function void apply_request(bit op, logic [7:0] rx);
      outcome_t   exp;
      logic [7:0] ch;
      logic [8:0] entry;
      bit         canon;
      bit         ext;
      bit         done;
      canon = cfg.input_flags[FL_CANON];
      ext   = cfg.input_flags[FL_EXTEND];
      exp.status    = ST_QUEUED;
      exp.kind      = SIG_NONE;
      exp.data_byte = 8'h00;
      exp.was_sep   = 1'b0;
      done = 1'b0;
      if (op == OP_POP) begin
        if ((canon ? sep_cnt > 0 : byte_cnt > 0) && byte_cnt != 0) begin
          entry = char_store[head_idx];
          head_idx = (head_idx + 1) % QUEUE_DEPTH;
          byte_cnt--;
          exp.data_byte = entry[7:0];
          exp.was_sep   = entry[8];
          if (entry[8] && sep_cnt > 0) sep_cnt--;
          exp.status = ST_POPPED;
        end else begin
          exp.status = ST_NONE;
        end
      end else if (!canon) begin
        exp.status = store_byte(rx, is_line_end(rx));
      end else begin
        ch = rx;
        if (cfg.input_flags[FL_STRIP]) ch &= STRIP_MASK;
        if (cfg.input_flags[FL_LCASE] && ext && ch >= CH_UC_A && ch <= CH_UC_Z)
          ch += CASE_OFFSET;
        // ignoring CR takes priority over mapping it
        if (ch == CH_CR) begin
          if (cfg.input_flags[FL_IGNCR]) begin
            exp.status = ST_CR_IGNORED;
            done = 1'b1;
          end else if (cfg.input_flags[FL_ICRNL]) begin
            ch = CH_NL;
          end
        end else if (ch == CH_NL && cfg.input_flags[FL_INLCR]) begin
          ch = CH_CR;
        end
        if (!done && cfg.input_flags[FL_ISIG]) begin
          if (ch == cfg.signal_chars[7:0])        exp.kind = SIG_INTR;
          else if (ch == cfg.signal_chars[15:8])  exp.kind = SIG_QUIT;
          else if (ch == cfg.signal_chars[23:16]) exp.kind = SIG_SUSP;
          if (exp.kind != SIG_NONE) begin
            exp.status = ST_SIGNAL;
            done = 1'b1;
          end
        end
        // erase, kill and word erase all drop just the last byte
        if (!done && (ch == cfg.erase_chars[7:0] || ch == cfg.erase_chars[15:8] ||
                      (ext && ch == cfg.erase_chars[23:16]))) begin
          if (byte_cnt == 0) begin
            exp.status = ST_ERASE_EMPTY;
          end else begin
            tail_idx = (tail_idx + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
            byte_cnt--;
            if (char_store[tail_idx][8] && sep_cnt > 0) sep_cnt--;
            exp.status = ST_ERASED;
          end
          done = 1'b1;
        end
        if (!done) begin
          if (ch == cfg.eof_code) exp.status = store_byte(CH_ZERO, 1'b1);
          else                    exp.status = store_byte(ch, is_line_end(ch));
        end
      end
      exp.fill     = byte_cnt[10:0];
      exp.lines    = sep_cnt[10:0];
      exp.readable = canon ? (sep_cnt > 0) : (byte_cnt > 0);
      exp.writable = byte_cnt < QUEUE_DEPTH;
      pending_outcomes.push_back(exp);
    endfunction

    // four-state compare so that unknown bits count as a mismatch
    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
      outcome_t exp;
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result with nothing pending, status %0d data %h",
                 $time, user, data);
        errors++;
        return;
      end
      exp = pending_outcomes.pop_front();
      compare_field("status", 32'(exp.status), 32'(user));
      compare_field("signal_kind", 32'(exp.kind), 32'(data[1:0]));
      compare_field("data_byte", 32'(exp.data_byte), 32'(data[9:2]));
      compare_field("was_separator", 32'(exp.was_sep), 32'(data[10]));
      compare_field("fill_count", 32'(exp.fill), 32'(data[21:11]));
      compare_field("line_count", 32'(exp.lines), 32'(data[32:22]));
      compare_field("readable", 32'(exp.readable), 32'(data[33]));
      compare_field("writable", 32'(exp.writable), 32'(data[34]));
      compare_field("padding", '0, 32'(data[39:35]));
    endfunction
  endclass

  // clock, reset and block inputs, all known from time zero
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;  // rx_byte[7:0]
  logic                   s_axis_tuser  = 1'b0; // op
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // signal_kind[1:0], data_byte[9:2], was_separator[10], fill_count[21:11],
  // line_count[32:22], readable[33], writable[34], zero[39:35]
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic [OUT_USER_W-1:0]  m_axis_tuser;  // status[2:0]
  logic                   cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;

  line_queue_scoreboard line_sb = new();
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;

  always #6 clk_i = ~clk_i;

  tty_canonical_input_queue_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // offer one request; the sender runs in bursts with random gaps in between
  task automatic send_request(bit op, logic [7:0] rx);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= rx;
    // tready seen here is its value just before the edge
    do @(posedge clk_i); while (!s_axis_tready);
    line_sb.apply_request(op, rx);
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (line_sb.pending_outcomes.size() != 0) @(posedge clk_i);
    // input and output registers, a little margin on top
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    line_sb.write_reg(idx, val);
  endtask

  // rewrite all registers; only called with the block idle
  task automatic apply_config(logic [7:0] flags, logic [23:0] sig_chars,
                              logic [23:0] erase_chars, logic [7:0] eof_ch,
                              logic [7:0] eol_ch);
    write_reg(REG_INPUT_FLAGS, {16'h0, flags});
    write_reg(REG_SIGNAL_CHARS, sig_chars);
    write_reg(REG_ERASE_CHARS, erase_chars);
    write_reg(REG_EOF_CODE, {16'h0, eof_ch});
    write_reg(REG_EOL_CHAR, {16'h0, eol_ch});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // byte mix: mostly text in canonical mode, with line ends, signal and erase
  // chars of the current setting sprinkled in so that lines form and get edited
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 19))
      0, 1: begin
        case ($urandom_range(0, 3))
          0: b = CH_NL;
          1: b = CH_CR;
          2: b = line_sb.cfg.eol_char;
          default: b = line_sb.cfg.eof_code;
        endcase
      end
      2: b = line_sb.cfg.signal_chars[8 * $urandom_range(0, 2) +: 8];
      3: b = line_sb.cfg.erase_chars[8 * $urandom_range(0, 2) +: 8];
      4: b = 8'($urandom_range(0, 255));
      default: begin
        if (line_sb.cfg.input_flags[FL_CANON]) b = 8'($urandom_range(8'h20, 8'h7E));
        else                                   b = 8'($urandom_range(0, 255));
      end
    endcase
    return b;
  endfunction

  task automatic run_random(int unsigned count, int unsigned pop_pct);
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < pop_pct) send_request(OP_POP, 8'($urandom_range(0, 255)));
      else                                 send_request(OP_RECEIVE, pick_byte());
    end
  endtask

  // result side: stretches of always ready, coin flip, sparse and rotating
  // patterns, plus long hold-offs that back the pipeline up into the sender
  initial begin
    int unsigned stretch;
    int unsigned mode;
    logic [7:0]  stall_pat;
    stretch   = 0;
    stall_pat = 8'b1011_0010;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stretch++;
      mode = $urandom_range(0, 3);
      if (stretch == 3 || $urandom_range(0, 15) == 0) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(10, 100)) begin
          case (mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: begin
              m_axis_tready <= stall_pat[0];
              stall_pat = {stall_pat[0], stall_pat[7:1]};
            end
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      line_sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("tty_canonical_input_queue_unit_tb failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // canonical with strip and lowercase on, default control chars
    apply_config(8'hAF, RST_SIGNAL_CHARS, RST_ERASE_CHARS, RST_EOF_CODE, RST_EOL_CHAR);

    // directed: empty queue cases first
    send_request(OP_POP, 8'hFF);       // pop with nothing readable
    send_request(OP_RECEIVE, 8'h7F);   // erase on empty queue
    send_request(OP_RECEIVE, 8'h41);   // uppercase folded to lowercase
    send_request(OP_RECEIVE, 8'hDA);   // high bit stripped, then folded
    send_request(OP_POP, 8'h00);       // bytes queued but no complete line
    send_request(OP_RECEIVE, 8'h03);   // interrupt
    send_request(OP_RECEIVE, 8'h1C);   // quit
    send_request(OP_RECEIVE, 8'h1A);   // suspend
    send_request(OP_RECEIVE, 8'h00);   // zero byte queued
    send_request(OP_RECEIVE, 8'h7F);   // erase
    send_request(OP_RECEIVE, 8'h15);   // kill drops one byte only
    send_request(OP_RECEIVE, 8'h17);   // word erase, extended is on
    send_request(OP_RECEIVE, 8'h71);
    send_request(OP_RECEIVE, CH_CR);   // CR mapped to a marked NL
    send_request(OP_RECEIVE, 8'h04);   // EOF queued as marked zero
    send_request(OP_RECEIVE, CH_NL);
    send_request(OP_RECEIVE, 8'h78);
    send_request(OP_RECEIVE, CH_NL);
    send_request(OP_RECEIVE, 8'h7F);   // erase of a marked byte drops its mark
    repeat (5) send_request(OP_POP, 8'h00);  // last pop finds no full line
    drain_results();

    // mixed traffic in the same setting
    run_random(150, 35);
    drain_results();

    // every flag set, all-ones signal chars, NUL erases; lines only end at EOL
    apply_config(8'hFF, 24'hFFFFFF, 24'h000000, 8'hFF, 8'h2E);
    run_random(150, 35);
    drain_results();

    // raw mode with all-zero chars and an all-ones EOL
    apply_config(8'h00, 24'h000000, 24'h000000, 8'h00, 8'hFF);
    run_random(150, 45);
    drain_results();

    // random settings, several times over
    repeat (3) begin
      apply_config(8'($urandom_range(0, 255)), 24'($urandom()), 24'($urandom()),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      run_random(60, 35);
      drain_results();
    end

    // canonical only: no strip, no fold, no signals, no word erase
    apply_config(8'h01, RST_SIGNAL_CHARS, RST_ERASE_CHARS, RST_EOF_CODE, 8'h3B);
    run_random(100, 35);
    drain_results();

    // fill the queue in raw mode and push past the end
    apply_config(8'h00, RST_SIGNAL_CHARS, RST_ERASE_CHARS, RST_EOF_CODE, RST_EOL_CHAR);
    while (line_sb.byte_cnt < QUEUE_DEPTH)
      send_request(OP_RECEIVE, 8'($urandom_range(0, 255)));
    repeat (4) send_request(OP_RECEIVE, 8'($urandom_range(0, 255)));
    drain_results();

    // full queue in canonical mode: signals, CR ignore and erase still act
    apply_config(8'h99, RST_SIGNAL_CHARS, RST_ERASE_CHARS, RST_EOF_CODE, RST_EOL_CHAR);
    send_request(OP_RECEIVE, 8'h03);
    send_request(OP_RECEIVE, CH_CR);
    send_request(OP_RECEIVE, 8'h6B);
    send_request(OP_RECEIVE, 8'h7F);
    send_request(OP_RECEIVE, CH_NL);
    send_request(OP_RECEIVE, 8'h6D);
    run_random(80, 50);
    drain_results();

    repeat (10) @(posedge clk_i);
    if (line_sb.errors == 0 && line_sb.pending_outcomes.size() == 0) begin
      $display("tty_canonical_input_queue_unit_tb passed");
    end else begin
      $display("tty_canonical_input_queue_unit_tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/ttyciq_pkg.sv
hw/rtl/ttyciq_classify.sv
hw/rtl/tty_canonical_input_queue_unit.sv
tb/tty_canonical_input_queue_unit_tb.sv
